FILE: rtl/core/toc_pkg.sv
// Shared types, sizes and codes of the tile occupancy compactor.
package toc_pkg;

   localparam int MAX_PIXELS  = 4096;
   localparam int ADDR_W      = $clog2(MAX_PIXELS);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int BYTE_DEPTH  = (MAX_PIXELS + 7) / 8;
   localparam int BYTE_ADDR_W = $clog2(BYTE_DEPTH);
   localparam int TOTAL_W     = 13;
   localparam int VALUE_W     = 32;
   localparam int SUPPORT_W   = 8;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   typedef enum logic [2:0] {
      PH_LOAD,
      PH_HEADER,
      PH_OCC,
      PH_SIGNAL,
      PH_SUPPORT,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      SEC_HEADER  = 3'd0,
      SEC_OCC     = 3'd1,
      SEC_SIGNAL  = 3'd2,
      SEC_SUPPORT = 3'd3,
      SEC_NONE    = 3'd4
   } section_type;

   typedef enum logic [1:0] {
      MODE_FULL   = 2'd0,
      MODE_BITMAP = 2'd1,
      MODE_SPARSE = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PICK,
      ST_RD_INDEX,
      ST_RD_DATA,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic      load;
      logic      new_tile;
      logic      pick;
      logic      ptr_clear;
      logic      ptr_inc;
      logic      rsp_load;
      logic      rsp_idle;
      logic      rsp_last;
      phase_type phase;
   } cmd_type;

   typedef struct packed {
      logic occ_empty;
      logic data_empty;
      logic ptr_at_end;
      logic rsp_free;
   } status_type;

endpackage

FILE: rtl/core/toc_ctrl.sv
// Controller: load/fetch sequencing and drain phase tracking.
module toc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_opcode,
   input  logic                req_last_pixel,
   input  toc_pkg::status_type status,
   output toc_pkg::cmd_type    cmd
);

   toc_pkg::state_type state_ff, state_in;
   toc_pkg::phase_type phase_ff, phase_in;
   toc_pkg::phase_type phase_next;
   logic               accept;
   logic               pending;
   logic               section_end;

   assign accept      = req_valid && (state_ff == toc_pkg::ST_IDLE);
   assign pending     = (phase_ff != toc_pkg::PH_LOAD) && (phase_ff != toc_pkg::PH_DONE);
   assign section_end = (phase_ff == toc_pkg::PH_HEADER) || status.ptr_at_end;

   // following non-empty section
   always_comb begin
      unique case (phase_ff)
         toc_pkg::PH_HEADER: begin
            if (!status.occ_empty) begin
               phase_next = toc_pkg::PH_OCC;
            end else if (!status.data_empty) begin
               phase_next = toc_pkg::PH_SIGNAL;
            end else begin
               phase_next = toc_pkg::PH_DONE;
            end
         end
         toc_pkg::PH_OCC: begin
            phase_next = status.data_empty ? toc_pkg::PH_DONE : toc_pkg::PH_SIGNAL;
         end
         toc_pkg::PH_SIGNAL:  phase_next = toc_pkg::PH_SUPPORT;
         toc_pkg::PH_SUPPORT: phase_next = toc_pkg::PH_DONE;
         default:             phase_next = phase_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      unique case (state_ff)
         toc_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_opcode == toc_pkg::OP_LOAD) begin
                  phase_in = toc_pkg::PH_LOAD;
                  if (req_last_pixel) begin
                     state_in = toc_pkg::ST_PICK;
                  end
               end else begin
                  state_in = toc_pkg::ST_RD_INDEX;
               end
            end
         end
         toc_pkg::ST_PICK: begin
            state_in = toc_pkg::ST_IDLE;
            phase_in = toc_pkg::PH_HEADER;
         end
         toc_pkg::ST_RD_INDEX: state_in = toc_pkg::ST_RD_DATA;
         toc_pkg::ST_RD_DATA:  state_in = toc_pkg::ST_OUT;
         toc_pkg::ST_OUT: begin
            if (status.rsp_free) begin
               state_in = toc_pkg::ST_IDLE;
               if (pending && section_end) begin
                  phase_in = phase_next;
               end
            end
         end
         default: state_in = toc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = (state_ff == toc_pkg::ST_IDLE);
      cmd           = '0;
      cmd.phase     = phase_ff;
      cmd.load      = accept && (req_opcode == toc_pkg::OP_LOAD);
      cmd.new_tile  = cmd.load && (phase_ff != toc_pkg::PH_LOAD);
      cmd.pick      = (state_ff == toc_pkg::ST_PICK);
      cmd.ptr_clear = cmd.pick || cmd.new_tile;
      if ((state_ff == toc_pkg::ST_OUT) && status.rsp_free) begin
         cmd.rsp_load = 1'b1;
         cmd.rsp_idle = !pending;
         if (pending) begin
            cmd.ptr_clear = section_end;
            cmd.ptr_inc   = !section_end;
            cmd.rsp_last  = section_end && (phase_next == toc_pkg::PH_DONE);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= toc_pkg::ST_IDLE;
         phase_ff <= toc_pkg::PH_LOAD;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

FILE: rtl/core/toc_datapath.sv
// Datapath: pixel stores, counters, mode pick, drain reads and result register.
module toc_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  toc_pkg::cmd_type                cmd,
   output toc_pkg::status_type             status,
   input  logic                            req_pixel_valid,
   input  logic [toc_pkg::VALUE_W-1:0]     req_signal_bits,
   input  logic [toc_pkg::SUPPORT_W-1:0]   req_support_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [2:0]                      rsp_section,
   output logic [1:0]                      rsp_mode,
   output logic [toc_pkg::VALUE_W-1:0]     rsp_value,
   output logic [toc_pkg::TOTAL_W-1:0]     rsp_pixel_total,
   output logic                            rsp_overflow,
   output logic                            rsp_last_of_tile
);

   localparam int ADDR_W      = toc_pkg::ADDR_W;
   localparam int CNT_W       = toc_pkg::CNT_W;
   localparam int BYTE_ADDR_W = toc_pkg::BYTE_ADDR_W;

   logic [toc_pkg::VALUE_W-1:0]   sig_mem  [toc_pkg::MAX_PIXELS];
   logic [toc_pkg::SUPPORT_W-1:0] sup_mem  [toc_pkg::MAX_PIXELS];
   logic [7:0]                    byte_mem [toc_pkg::BYTE_DEPTH];
   logic [ADDR_W-1:0]             idx_mem  [toc_pkg::MAX_PIXELS];

   logic [CNT_W-1:0]  pix_cnt_ff, pix_cnt_in;
   logic [CNT_W-1:0]  valid_cnt_ff, valid_cnt_in;
   logic              dropped_ff, dropped_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [7:0]        acc_ff, acc_in;
   toc_pkg::mode_type mode_ff, mode_in;
   logic [CNT_W-1:0]  occ_len_ff, occ_len_in;
   logic [CNT_W-1:0]  data_len_ff, data_len_in;

   logic [CNT_W-1:0]  p_eff, v_eff;
   logic              room;
   logic              store_en;
   logic [CNT_W:0]    bytes_needed;
   logic [CNT_W+1:0]  valid_x4;
   logic [CNT_W-1:0]  ptr_plus;
   logic [CNT_W-1:0]  cur_len;

   logic [toc_pkg::VALUE_W-1:0]   sig_q;
   logic [toc_pkg::SUPPORT_W-1:0] sup_q;
   logic [7:0]                    byte_q;
   logic [ADDR_W-1:0]             idx_q;
   logic [ADDR_W-1:0]             data_addr;

   logic                          rsp_valid_ff, rsp_valid_in;
   toc_pkg::section_type          section_ff, section_in;
   toc_pkg::mode_type             rmode_ff, rmode_in;
   logic [toc_pkg::VALUE_W-1:0]   value_ff, value_in;
   logic [toc_pkg::TOTAL_W-1:0]   total_ff, total_in;
   logic                          ovf_ff, ovf_in;
   logic                          last_ff, last_in;

   // loading
   always_comb begin
      p_eff        = cmd.new_tile ? '0 : pix_cnt_ff;
      v_eff        = cmd.new_tile ? '0 : valid_cnt_ff;
      room         = (p_eff != CNT_W'(toc_pkg::MAX_PIXELS));
      store_en     = cmd.load && room;
      acc_in       = (p_eff[2:0] == 3'd0) ? 8'd0 : acc_ff;
      acc_in       = acc_in | (8'(req_pixel_valid) << p_eff[2:0]);
      pix_cnt_in   = pix_cnt_ff;
      valid_cnt_in = valid_cnt_ff;
      dropped_in   = dropped_ff;
      if (cmd.load) begin
         pix_cnt_in   = room ? p_eff + 1'b1 : p_eff;
         valid_cnt_in = (room && req_pixel_valid) ? v_eff + 1'b1 : v_eff;
         dropped_in   = (cmd.new_tile ? 1'b0 : dropped_ff) | !room;
      end
   end

   // mode pick
   always_comb begin
      bytes_needed = ((CNT_W + 1)'(pix_cnt_ff) + (CNT_W + 1)'(7)) >> 3;
      valid_x4     = (CNT_W + 2)'(valid_cnt_ff) << 2;
      priority if ((pix_cnt_ff == '0) || (valid_cnt_ff == pix_cnt_ff)) begin
         mode_in = toc_pkg::MODE_FULL;
      end else if (valid_x4 < (CNT_W + 2)'(bytes_needed)) begin
         mode_in = toc_pkg::MODE_SPARSE;
      end else begin
         mode_in = toc_pkg::MODE_BITMAP;
      end
      unique case (mode_in)
         toc_pkg::MODE_BITMAP: occ_len_in = bytes_needed[CNT_W-1:0];
         toc_pkg::MODE_SPARSE: occ_len_in = valid_cnt_ff;
         default:              occ_len_in = '0;
      endcase
      data_len_in = (mode_in == toc_pkg::MODE_FULL) ? pix_cnt_ff : valid_cnt_ff;
   end

   // drain pointer and section bounds
   always_comb begin
      ptr_plus = ptr_ff + 1'b1;
      unique case (cmd.phase)
         toc_pkg::PH_OCC:     cur_len = occ_len_ff;
         toc_pkg::PH_SIGNAL,
         toc_pkg::PH_SUPPORT: cur_len = data_len_ff;
         default:             cur_len = CNT_W'(1);
      endcase
      ptr_in = ptr_ff;
      priority if (cmd.ptr_clear) begin
         ptr_in = '0;
      end else if (cmd.ptr_inc) begin
         ptr_in = ptr_plus;
      end
      status.occ_empty  = (occ_len_ff == '0);
      status.data_empty = (data_len_ff == '0);
      status.ptr_at_end = (ptr_plus == cur_len);
      status.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   assign data_addr = (mode_ff == toc_pkg::MODE_FULL) ? ptr_ff[ADDR_W-1:0] : idx_q;

   always_ff @(posedge clock) begin
      if (store_en) begin
         sig_mem[p_eff[ADDR_W-1:0]]             <= req_signal_bits;
         sup_mem[p_eff[ADDR_W-1:0]]             <= req_support_value;
         byte_mem[p_eff[ADDR_W-1:3]]            <= acc_in;
         if (req_pixel_valid) begin
            idx_mem[v_eff[ADDR_W-1:0]] <= p_eff[ADDR_W-1:0];
         end
      end
      idx_q  <= idx_mem[ptr_ff[ADDR_W-1:0]];
      byte_q <= byte_mem[ptr_ff[BYTE_ADDR_W-1:0]];
      sig_q  <= sig_mem[data_addr];
      sup_q  <= sup_mem[data_addr];
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      section_in   = section_ff;
      rmode_in     = rmode_ff;
      value_in     = value_ff;
      total_in     = total_ff;
      ovf_in       = ovf_ff;
      last_in      = last_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rmode_in     = mode_ff;
         total_in     = toc_pkg::TOTAL_W'(pix_cnt_ff);
         ovf_in       = dropped_ff;
         last_in      = cmd.rsp_last;
         unique case (cmd.phase)
            toc_pkg::PH_HEADER: begin
               section_in = toc_pkg::SEC_HEADER;
               value_in   = toc_pkg::VALUE_W'(valid_cnt_ff);
            end
            toc_pkg::PH_OCC: begin
               section_in = toc_pkg::SEC_OCC;
               value_in   = (mode_ff == toc_pkg::MODE_BITMAP) ?
                            toc_pkg::VALUE_W'(byte_q) : toc_pkg::VALUE_W'(idx_q);
            end
            toc_pkg::PH_SIGNAL: begin
               section_in = toc_pkg::SEC_SIGNAL;
               value_in   = sig_q;
            end
            toc_pkg::PH_SUPPORT: begin
               section_in = toc_pkg::SEC_SUPPORT;
               value_in   = toc_pkg::VALUE_W'(sup_q);
            end
            default: begin
               section_in = toc_pkg::SEC_NONE;
               value_in   = '0;
            end
         endcase
         if (cmd.rsp_idle) begin
            section_in = toc_pkg::SEC_NONE;
            rmode_in   = toc_pkg::MODE_FULL;
            value_in   = '0;
            total_in   = '0;
            ovf_in     = 1'b0;
            last_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_cnt_ff   <= '0;
         valid_cnt_ff <= '0;
         dropped_ff   <= 1'b0;
         ptr_ff       <= '0;
         mode_ff      <= toc_pkg::MODE_FULL;
         occ_len_ff   <= '0;
         data_len_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pix_cnt_ff   <= pix_cnt_in;
         valid_cnt_ff <= valid_cnt_in;
         dropped_ff   <= dropped_in;
         ptr_ff       <= ptr_in;
         if (cmd.pick) begin
            mode_ff     <= mode_in;
            occ_len_ff  <= occ_len_in;
            data_len_ff <= data_len_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_en) begin
         acc_ff <= acc_in;
      end
      section_ff <= section_in;
      rmode_ff   <= rmode_in;
      value_ff   <= value_in;
      total_ff   <= total_in;
      ovf_ff     <= ovf_in;
      last_ff    <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_section      = section_ff;
   assign rsp_mode         = rmode_ff;
   assign rsp_value        = value_ff;
   assign rsp_pixel_total  = total_ff;
   assign rsp_overflow     = ovf_ff;
   assign rsp_last_of_tile = last_ff;

endmodule

FILE: rtl/core/tile_occupancy_compactor_core.sv
// Top level of the tile occupancy compactor: controller, datapath and checks.
// A load word leaves the controller idle; one with the last-pixel mark leads to
// the pick state, where the occupancy mode is picked. A fetch word holds off
// requests through an index memory read, a signal/support read at that index
// (the pointer in full mode) and the result register load once that is free.
// Pixel memories need no clearing after reset, so words are accepted at once.
module tile_occupancy_compactor_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_opcode,
   input  logic                          req_pixel_valid,
   input  logic [toc_pkg::VALUE_W-1:0]   req_signal_bits,
   input  logic [toc_pkg::SUPPORT_W-1:0] req_support_value,
   input  logic                          req_last_pixel,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_section,
   output logic [1:0]                    rsp_mode,
   output logic [toc_pkg::VALUE_W-1:0]   rsp_value,
   output logic [toc_pkg::TOTAL_W-1:0]   rsp_pixel_total,
   output logic                          rsp_overflow,
   output logic                          rsp_last_of_tile
);

   toc_pkg::cmd_type    cmd;
   toc_pkg::status_type status;

   toc_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_last_pixel (req_last_pixel),
      .status         (status),
      .cmd            (cmd)
   );

   toc_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_pixel_valid   (req_pixel_valid),
      .req_signal_bits   (req_signal_bits),
      .req_support_value (req_support_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_section       (rsp_section),
      .rsp_mode          (rsp_mode),
      .rsp_value         (rsp_value),
      .rsp_pixel_total   (rsp_pixel_total),
      .rsp_overflow      (rsp_overflow),
      .rsp_last_of_tile  (rsp_last_of_tile)
   );

   a_fetch_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_opcode == toc_pkg::OP_FETCH)) |=> !req_ready)
      else $error("fetch word did not hold off the request channel");

   a_rsp_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> status.rsp_free)
      else $error("result register overwritten while a word is pending");

   a_pick_after_last: assert property (@(posedge clock) disable iff (reset)
      cmd.pick |-> $past(req_valid && req_ready && (req_opcode == toc_pkg::OP_LOAD)
                         && req_last_pixel))
      else $error("mode pick without a closing load word");

   a_ptr_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd.ptr_inc |-> (cmd.rsp_load && !cmd.ptr_clear && !cmd.load))
      else $error("drain pointer advanced outside a result load");

endmodule

FILE: test/tb_tile_occupancy_compactor_core.sv
// Testbench for tile_occupancy_compactor_core: directed and random tiles checked by a predictor.
`timescale 1ns / 100ps

module tb_tile_occupancy_compactor_core;

   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 20;
   localparam int RANDOM_WORDS = 850;

   typedef struct packed {
      logic [2:0]                  sec;
      logic [1:0]                  mode;
      logic [toc_pkg::VALUE_W-1:0] value;
      logic [toc_pkg::TOTAL_W-1:0] total;
      logic                        ovf;
      logic                        last;
   } result_word_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic                          req_opcode;
   logic                          req_pixel_valid;
   logic [toc_pkg::VALUE_W-1:0]   req_signal_bits;
   logic [toc_pkg::SUPPORT_W-1:0] req_support_value;
   logic                          req_last_pixel;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [2:0]                    rsp_section;
   logic [1:0]                    rsp_mode;
   logic [toc_pkg::VALUE_W-1:0]   rsp_value;
   logic [toc_pkg::TOTAL_W-1:0]   rsp_pixel_total;
   logic                          rsp_overflow;
   logic                          rsp_last_of_tile;

   result_word_type result_q[$];
   int  mismatch_count = 0;
   int  words_sent = 0;
   bit  idle_on = 1'b1;
   int  hold_requested = 0;
   int  hold_served = 0;

   // predictor state
   logic [toc_pkg::VALUE_W-1:0]   tile_signal [toc_pkg::MAX_PIXELS];
   logic [toc_pkg::SUPPORT_W-1:0] tile_support [toc_pkg::MAX_PIXELS];
   logic [7:0]                    tile_occ [toc_pkg::BYTE_DEPTH];
   logic [toc_pkg::ADDR_W-1:0]    tile_index [toc_pkg::MAX_PIXELS];
   int unsigned                   tile_stored = 0;
   int unsigned                   tile_valid = 0;
   int unsigned                   drain_ptr = 0;
   toc_pkg::phase_type            drain_phase = toc_pkg::PH_LOAD;
   logic                          tile_dropped = 1'b0;
   toc_pkg::mode_type             tile_mode = toc_pkg::MODE_FULL;

   tile_occupancy_compactor_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_pixel_valid   (req_pixel_valid),
      .req_signal_bits   (req_signal_bits),
      .req_support_value (req_support_value),
      .req_last_pixel    (req_last_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_section       (rsp_section),
      .rsp_mode          (rsp_mode),
      .rsp_value         (rsp_value),
      .rsp_pixel_total   (rsp_pixel_total),
      .rsp_overflow      (rsp_overflow),
      .rsp_last_of_tile  (rsp_last_of_tile)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic int unsigned section_words(toc_pkg::phase_type ph);
      case (ph)
         toc_pkg::PH_HEADER: return 1;
         toc_pkg::PH_OCC: begin
            if (tile_mode == toc_pkg::MODE_BITMAP) return (tile_stored + 7) / 8;
            if (tile_mode == toc_pkg::MODE_SPARSE) return tile_valid;
            return 0;
         end
         toc_pkg::PH_SIGNAL, toc_pkg::PH_SUPPORT:
            return (tile_mode == toc_pkg::MODE_FULL) ? tile_stored : tile_valid;
         default: return 0;
      endcase
   endfunction

   task automatic predict_compaction(input logic op, input logic pv,
                                     input logic [toc_pkg::VALUE_W-1:0] sig,
                                     input logic [toc_pkg::SUPPORT_W-1:0] sup,
                                     input logic lst);
      result_word_type w;
      int unsigned     p;
      int unsigned     k;
      w = '0;
      w.sec = toc_pkg::SEC_NONE;
      if (op == toc_pkg::OP_LOAD) begin
         if (drain_phase != toc_pkg::PH_LOAD) begin
            tile_stored = 0;
            tile_valid = 0;
            tile_dropped = 1'b0;
            drain_ptr = 0;
            drain_phase = toc_pkg::PH_LOAD;
         end
         p = tile_stored;
         if (p < toc_pkg::MAX_PIXELS) begin
            tile_signal[p] = sig;
            tile_support[p] = sup;
            if (p % 8 == 0) tile_occ[p / 8] = 8'h00;
            if (pv) begin
               tile_occ[p / 8][p % 8] = 1'b1;
               tile_index[tile_valid] = toc_pkg::ADDR_W'(p);
               tile_valid++;
            end
            tile_stored = p + 1;
         end else begin
            tile_dropped = 1'b1;
         end
         if (lst) begin
            if (tile_stored == 0 || tile_valid == tile_stored) tile_mode = toc_pkg::MODE_FULL;
            else if (4 * tile_valid < (tile_stored + 7) / 8) tile_mode = toc_pkg::MODE_SPARSE;
            else tile_mode = toc_pkg::MODE_BITMAP;
            drain_phase = toc_pkg::PH_HEADER;
            drain_ptr = 0;
         end
      end else begin
         if (drain_phase != toc_pkg::PH_LOAD && drain_phase != toc_pkg::PH_DONE) begin
            k = drain_ptr;
            case (drain_phase)
               toc_pkg::PH_HEADER: begin
                  w.sec = toc_pkg::SEC_HEADER;
                  w.value = toc_pkg::VALUE_W'(tile_valid);
               end
               toc_pkg::PH_OCC: begin
                  w.sec = toc_pkg::SEC_OCC;
                  if (tile_mode == toc_pkg::MODE_BITMAP)
                     w.value = toc_pkg::VALUE_W'(tile_occ[k]);
                  else
                     w.value = toc_pkg::VALUE_W'(tile_index[k]);
               end
               default: begin
                  p = (tile_mode == toc_pkg::MODE_FULL) ? k : tile_index[k];
                  if (drain_phase == toc_pkg::PH_SIGNAL) begin
                     w.sec = toc_pkg::SEC_SIGNAL;
                     w.value = tile_signal[p];
                  end else begin
                     w.sec = toc_pkg::SEC_SUPPORT;
                     w.value = toc_pkg::VALUE_W'(tile_support[p]);
                  end
               end
            endcase
            drain_ptr = k + 1;
            while (drain_phase != toc_pkg::PH_DONE
                   && drain_ptr >= section_words(drain_phase)) begin
               drain_phase = toc_pkg::phase_type'(drain_phase + 1);
               drain_ptr = 0;
            end
            w.mode = tile_mode;
            w.total = toc_pkg::TOTAL_W'(tile_stored);
            w.ovf = tile_dropped;
            w.last = (drain_phase == toc_pkg::PH_DONE);
         end
         result_q.insert(result_q.size(), w);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         predict_compaction(req_opcode, req_pixel_valid, req_signal_bits,
                            req_support_value, req_last_pixel);
   end

   always @(posedge clock) begin : rsp_check
      result_word_type got;
      result_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.sec = rsp_section;
         got.mode = rsp_mode;
         got.value = rsp_value;
         got.total = rsp_pixel_total;
         got.ovf = rsp_overflow;
         got.last = rsp_last_of_tile;
         if (result_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected result word sec=%0d mode=%0d value=%h total=%0d",
                        $realtime, got.sec, got.mode, got.value, got.total);
         end else begin
            want = result_q.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: mismatch exp sec=%0d mode=%0d value=%h total=%0d ovf=%b last=%b",
                           $realtime, want.sec, want.mode, want.value, want.total, want.ovf,
                           want.last);
                  $display("%0t:          got sec=%0d mode=%0d value=%h total=%0d ovf=%b last=%b",
                           $realtime, got.sec, got.mode, got.value, got.total, got.ovf,
                           got.last);
               end
            end
         end
      end
   end

   // receiver: random stall bursts plus the long hold-off on request
   initial begin : rsp_side
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
            if (hold_left == 0) hold_served++;
         end else if (hold_requested != hold_served) begin
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_word(input logic op, input logic pv,
                            input logic [toc_pkg::VALUE_W-1:0] sig,
                            input logic [toc_pkg::SUPPORT_W-1:0] sup, input logic lst);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_pixel_valid <= pv;
      req_signal_bits <= sig;
      req_support_value <= sup;
      req_last_pixel <= lst;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic fetch_words(input int count);
      for (int i = 0; i < count; i++)
         send_word(toc_pkg::OP_FETCH, 1'($urandom_range(0, 1)), $urandom,
                   toc_pkg::SUPPORT_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   function automatic logic [toc_pkg::VALUE_W-1:0] pick_signal();
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      return $urandom;
   endfunction

   task automatic load_pixel(input logic pv, input logic lst);
      send_word(toc_pkg::OP_LOAD, pv, pick_signal(),
                toc_pkg::SUPPORT_W'($urandom_range(0, 255)), lst);
   endtask

   // pct: chance in percent that a pixel is valid; noisy adds stray fetch words
   task automatic load_tile(input int count, input int pct, input bit noisy, output int n_valid);
      logic pv;
      n_valid = 0;
      for (int i = 0; i < count; i++) begin
         if (noisy && i > 0 && $urandom_range(0, 19) == 0) fetch_words(1);
         pv = ($urandom_range(0, 99) < pct);
         if (pv) n_valid++;
         load_pixel(pv, i == count - 1);
      end
   endtask

   function automatic int drain_length(input int n, input int v);
      int occ;
      if (v == n) occ = 0;
      else if (4 * v < (n + 7) / 8) occ = v;
      else occ = (n + 7) / 8;
      return 1 + occ + 2 * ((v == n) ? n : v);
   endfunction

   task automatic test_fetch_while_loading();
      fetch_words(2);
   endtask

   task automatic test_edge_tiles();
      load_pixel(1'b0, 1'b1);
      fetch_words(2);
      load_pixel(1'b1, 1'b1);
      fetch_words(3);
      send_word(toc_pkg::OP_LOAD, 1'b1, 32'h0, 8'h00, 1'b0);
      send_word(toc_pkg::OP_LOAD, 1'b0, 32'hFFFF_FFFF, 8'hFF, 1'b0);
      for (int i = 2; i < 8; i++) load_pixel(1'b1, 1'b0);
      send_word(toc_pkg::OP_LOAD, 1'b1, 32'hFFFF_FFFF, 8'hFF, 1'b1);
      fetch_words(drain_length(9, 8) + 1);
   endtask

   // 64 pixels with two valid sits on the strict boundary; 65 crosses it
   task automatic test_sparse_boundary();
      for (int i = 0; i < 64; i++) load_pixel(i == 0 || i == 63, i == 63);
      fetch_words(drain_length(64, 2));
      for (int i = 0; i < 65; i++) load_pixel(i == 0 || i == 64, i == 64);
      fetch_words(drain_length(65, 2));
   endtask

   task automatic test_abandon_drain();
      int nv;
      load_tile(10, 50, 1'b0, nv);
      fetch_words(3);
      load_tile(5, 100, 1'b0, nv);
      fetch_words(drain_length(5, nv));
   endtask

   task automatic test_backpressure();
      int nv;
      idle_on = 1'b0;
      hold_requested++;
      load_tile(30, 50, 1'b0, nv);
      fetch_words(drain_length(30, nv));
      idle_on = 1'b1;
   endtask

   task automatic test_random_tiles();
      int start;
      int n;
      int nv;
      int pct;
      int r;
      int total;
      start = words_sent;
      while (words_sent - start < RANDOM_WORDS) begin
         idle_on = ($urandom_range(0, 3) != 0);
         r = $urandom_range(0, 9);
         if (r < 6) n = $urandom_range(1, 16);
         else if (r < 9) n = $urandom_range(17, 80);
         else n = $urandom_range(81, 300);
         case ($urandom_range(0, 4))
            0: pct = 100;
            1: pct = 0;
            2: pct = 3;
            3: pct = 50;
            default: pct = $urandom_range(0, 100);
         endcase
         if ($urandom_range(0, 7) == 0) fetch_words($urandom_range(1, 2));
         load_tile(n, pct, $urandom_range(0, 3) == 0, nv);
         total = drain_length(n, nv);
         if ($urandom_range(0, 9) < 7) fetch_words(total + $urandom_range(0, 2));
         else fetch_words($urandom_range(0, total - 1));
      end
   endtask

   task automatic test_quiet_tail();
      int nv;
      int n;
      idle_on = 1'b0;
      for (int t = 0; t < 5; t++) begin
         n = $urandom_range(1, 20);
         load_tile(n, $urandom_range(0, 100), 1'b0, nv);
         fetch_words(drain_length(n, nv) + 1);
      end
   endtask

   initial begin
      req_valid = 1'b0;
      req_opcode = toc_pkg::OP_LOAD;
      req_pixel_valid = 1'b0;
      req_signal_bits = '0;
      req_support_value = '0;
      req_last_pixel = 1'b0;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fetch_while_loading();
      test_edge_tiles();
      test_sparse_boundary();
      test_abandon_drain();
      test_backpressure();
      test_random_tiles();
      test_quiet_tail();
      req_valid <= 1'b0;
      while (result_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && result_q.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
